// ===== rtl/core/dkx_pkg.sv =====
package dkx_pkg;

  // Field widths of the result channel.
  localparam int KmerBits  = 64;
  localparam int StartBits = 40;
  localparam int SeqBits   = 24;

  // Characters of the FASTA text that the parser reacts to.
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharMarker  = 8'h3E;
  localparam logic [7:0] CharA       = 8'h41;
  localparam logic [7:0] CharC       = 8'h43;
  localparam logic [7:0] CharG       = 8'h47;
  localparam logic [7:0] CharT       = 8'h54;
  localparam logic [7:0] CharUpperZ  = 8'h5A;
  localparam logic [7:0] CharLowerA  = 8'h61;
  localparam logic [7:0] CharLowerZ  = 8'h7A;

  // Two-bit base codes.
  localparam logic [1:0] CodeA = 2'd0;
  localparam logic [1:0] CodeC = 2'd1;
  localparam logic [1:0] CodeG = 2'd2;
  localparam logic [1:0] CodeT = 2'd3;

  typedef struct packed {
    logic       newline;
    logic       marker;
    logic       letter;
    logic       base;
    logic [1:0] code;
  } symbol_class_t;

  typedef struct packed {
    logic [KmerBits-1:0]  kmer;
    logic [StartBits-1:0] start_position;
    logic [SeqBits-1:0]   sequence_number;
  } result_t;

endpackage

// ===== rtl/core/dkx_decode.sv =====
module dkx_decode (
  input  logic [7:0]             symbol,
  output dkx_pkg::symbol_class_t cls
);

  always_comb begin
    cls.newline = (symbol == dkx_pkg::CharNewline);
    cls.marker  = (symbol == dkx_pkg::CharMarker);
    cls.letter  = ((symbol >= dkx_pkg::CharA) && (symbol <= dkx_pkg::CharUpperZ)) ||
                  ((symbol >= dkx_pkg::CharLowerA) && (symbol <= dkx_pkg::CharLowerZ));
    cls.base = 1'b1;
    cls.code = dkx_pkg::CodeA;
    unique case (symbol)
      dkx_pkg::CharA: cls.code = dkx_pkg::CodeA;
      dkx_pkg::CharC: cls.code = dkx_pkg::CodeC;
      dkx_pkg::CharG: cls.code = dkx_pkg::CodeG;
      dkx_pkg::CharT: cls.code = dkx_pkg::CodeT;
      default: begin
        // Any other letter shifts in a zero code and breaks the run.
        cls.base = 1'b0;
        cls.code = dkx_pkg::CodeA;
      end
    endcase
  end

endmodule

// ===== rtl/core/dkx_track.sv =====
module dkx_track #(
  parameter int KMER_LENGTH   = 32,
  parameter int POSITION_BITS = 40
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  dkx_pkg::symbol_class_t cls,
  output logic                   emit,
  output dkx_pkg::result_t       result
);

  localparam int ShiftBits = 2 * KMER_LENGTH;
  localparam int RunBits   = $clog2(KMER_LENGTH + 1);
  localparam logic [RunBits-1:0]       RunFull = RunBits'(KMER_LENGTH);
  localparam logic [POSITION_BITS-1:0] PosBack = POSITION_BITS'(KMER_LENGTH);

  logic [ShiftBits-1:0]       kmer_shift, kmer_shift_next;
  logic [RunBits-1:0]         run_length, run_length_next;
  logic [POSITION_BITS-1:0]   position_count, position_count_next;
  logic [dkx_pkg::SeqBits-1:0] sequence_count, sequence_count_next;
  logic                       in_header, in_header_next;
  logic [POSITION_BITS-1:0]   start_pos;

  always_comb begin
    kmer_shift_next     = kmer_shift;
    run_length_next     = run_length;
    position_count_next = position_count;
    sequence_count_next = sequence_count;
    in_header_next      = in_header;
    emit                = 1'b0;
    if (advance) begin
      priority if (in_header) begin
        if (cls.newline) begin
          in_header_next = 1'b0;
        end
      end else if (cls.marker) begin
        in_header_next      = 1'b1;
        sequence_count_next = sequence_count + 1'b1;
        run_length_next     = '0;
        position_count_next = position_count + 1'b1;
      end else if (cls.letter) begin
        kmer_shift_next = ShiftBits'({kmer_shift, cls.code});
        position_count_next = position_count + 1'b1;
        if (cls.base) begin
          run_length_next = (run_length == RunFull) ? RunFull : run_length + 1'b1;
        end else begin
          run_length_next = '0;
        end
        emit = cls.base && (run_length_next == RunFull);
      end else begin
        // Any other non-letter outside a header leaves the state alone.
      end
    end
  end

  assign start_pos = position_count_next - PosBack;

  always_comb begin
    result.kmer            = dkx_pkg::KmerBits'(kmer_shift_next);
    result.start_position  = dkx_pkg::StartBits'(start_pos);
    result.sequence_number = sequence_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_shift     <= '0;
      run_length     <= '0;
      position_count <= '0;
      sequence_count <= '0;
      in_header      <= 1'b1;
    end else begin
      kmer_shift     <= kmer_shift_next;
      run_length     <= run_length_next;
      position_count <= position_count_next;
      sequence_count <= sequence_count_next;
      in_header      <= in_header_next;
    end
  end

endmodule

// ===== rtl/core/dna_kmer_extractor_core.sv =====
// Path: an accepted symbol is registered in the input stage, parsed combinationally,
// and its k-mer is registered in the result register that drives the result ports.
// Throughput: one symbol per cycle; the input stage and the result register stall only
// while a finished k-mer waits on result_ready.
// Reset (rst, synchronous, active high): both stages empty, counters and the shift
// register cleared, and the parser placed inside the leading header line.
module dna_kmer_extractor_core #(
  parameter int KMER_LENGTH   = 32,
  parameter int POSITION_BITS = 40
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          symbol_valid,
  output logic                          symbol_ready,
  input  logic [7:0]                    symbol,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [dkx_pkg::KmerBits-1:0]  kmer,
  output logic [dkx_pkg::StartBits-1:0] start_position,
  output logic [dkx_pkg::SeqBits-1:0]   sequence_number
);

  // Input stage: one registered symbol waiting to be parsed.
  logic       stage_valid;
  logic [7:0] stage_symbol;

  // The parse step runs when the staged symbol can hand any result it makes to the
  // output register, that is when that register is empty or is being drained.
  logic advance;
  logic emit;

  dkx_pkg::symbol_class_t cls;
  dkx_pkg::result_t       result;
  dkx_pkg::result_t       result_q;

  assign advance      = stage_valid && (!result_valid || result_ready);
  assign symbol_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (symbol_ready) begin
      stage_valid <= symbol_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (symbol_ready && symbol_valid) begin
      stage_symbol <= symbol;
    end
  end

  dkx_decode u_decode (
    .symbol (stage_symbol),
    .cls    (cls)
  );

  // Parser state: header tracking, the base shift register, the run of valid bases,
  // and the position and sequence counters. It offers the next k-mer combinationally.
  dkx_track #(
    .KMER_LENGTH   (KMER_LENGTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cls     (cls),
    .emit    (emit),
    .result  (result)
  );

  // Result register. A waiting k-mer holds until it is taken; a symbol that makes no
  // k-mer still retires through the parse step whenever the register can move.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= emit;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      result_q <= result;
    end
  end

  assign kmer            = result_q.kmer;
  assign start_position  = result_q.start_position;
  assign sequence_number = result_q.sequence_number;

endmodule
